>>> sv/sobel_pkg.sv
// sobel_pkg: shared constants, types and helpers for the sobel edge block
// no dependencies; used by sobel_ctrl, sobel_dp and sobel_edge_threshold
package sobel_pkg;

    // line store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field widths
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 9;
    localparam int THR_W  = 11;
    localparam int MAG_W  = 11;

    // compare width for positions against clamped sizes
    localparam int POS_W  = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int CMP_W  = (POS_W > ROW_W + 1) ? POS_W : ROW_W + 1;

    // gradient arithmetic
    localparam int SUM_W      = PIX_W + 4;
    localparam int ABS_W      = SUM_W - 1;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int MAG_MAX    = 1442;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd255;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd255;
    localparam logic [THR_W-1:0] THRESH_RESET = 11'd100;
    localparam logic [DIM_W-1:0] DIM_MIN      = 9'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic advance;
        logic grad;
        logic square_x;
        logic square_y;
        logic root_step;
        logic load_out;
    } sobel_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic has_result;
        logic root_last;
        logic out_free;
    } sobel_status_t;

    // zero-extend a pixel into the signed gradient width
    function automatic logic signed [SUM_W-1:0] to_sum(input logic [PIX_W-1:0] p);
        return $signed({{(SUM_W-PIX_W){1'b0}}, p});
    endfunction

endpackage

>>> sv/sobel_ram.sv
// sobel_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module sobel_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sobel_ctrl.sv
// sobel_ctrl: sequencer for one pixel transaction through the datapath
// depends on sobel_pkg
module sobel_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sobel_pkg::sobel_status_t status,
    output sobel_pkg::sobel_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIN  = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQX  = 3'd3;
    localparam logic [2:0] S_SQY  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_SPARE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                // line store data is valid here
                cmd.advance = 1'b1;
                state_next  = status.has_result ? S_GRAD : S_IDLE;
            end
            S_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.square_x = 1'b1;
                state_next   = S_SQY;
            end
            S_SQY:
            begin
                cmd.square_y = 1'b1;
                state_next   = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SPARE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_to_win: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_WIN))
        else $error("accepted transaction did not reach the window step");

    a_root_length: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_ROOT) |-> ##(sobel_pkg::ROOT_STEPS) (state_reg == S_OUT))
        else $error("square root did not take the expected number of steps");

    a_no_spare: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SPARE) |=> (state_reg != S_SPARE))
        else $error("controller entered an unused state");
`endif

endmodule

>>> sv/sobel_dp.sv
// sobel_dp: line stores, 3x3 window, gradient, square root and output register
// depends on sobel_pkg and sobel_ram
module sobel_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [sobel_pkg::PIX_W-1:0]          pixel,
    input  sobel_pkg::sobel_cmd_t                cmd,
    output sobel_pkg::sobel_status_t             status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sobel_pkg::MAG_W-1:0]          magnitude,
    output logic                                 edge_res,
    output logic                                 frame_last
);

    localparam int PW = sobel_pkg::PIX_W;
    localparam int CW = sobel_pkg::COL_W;
    localparam int RW = sobel_pkg::ROW_W;
    localparam int DW = sobel_pkg::DIM_W;
    localparam int XW = sobel_pkg::CMP_W;
    localparam int SW = sobel_pkg::SUM_W;
    localparam int AW = sobel_pkg::ABS_W;
    localparam int QW = sobel_pkg::SQ_W;
    localparam int MW = sobel_pkg::MAG_W;
    localparam int TW = sobel_pkg::THR_W;

    // configuration
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [TW-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sobel_pkg::WIDTH_RESET;
            height_reg <= sobel_pkg::HEIGHT_RESET;
            thresh_reg <= sobel_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sobel_pkg::REG_WIDTH:  width_reg  <= cfg_data[DW-1:0];
                sobel_pkg::REG_HEIGHT: height_reg <= cfg_data[DW-1:0];
                sobel_pkg::REG_THRESH: thresh_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // clamped last column and last row
    logic [XW-1:0] width_x;
    logic [XW-1:0] height_x;
    logic [XW-1:0] width_c;
    logic [XW-1:0] height_c;
    logic [XW-1:0] last_col;
    logic [XW-1:0] last_row;
    logic [XW-1:0] col_x;
    logic [XW-1:0] row_x;

    assign width_x  = XW'(width_reg);
    assign height_x = XW'(height_reg);

    always_comb
    begin
        priority if (width_x < XW'(sobel_pkg::DIM_MIN))
            width_c = XW'(sobel_pkg::DIM_MIN);
        else if (width_x > XW'(sobel_pkg::MAX_WIDTH))
            width_c = XW'(sobel_pkg::MAX_WIDTH);
        else
            width_c = width_x;

        priority if (height_x < XW'(sobel_pkg::DIM_MIN))
            height_c = XW'(sobel_pkg::DIM_MIN);
        else if (height_x > XW'(sobel_pkg::MAX_HEIGHT))
            height_c = XW'(sobel_pkg::MAX_HEIGHT);
        else
            height_c = height_x;
    end

    assign last_col = width_c - XW'(1);
    assign last_row = height_c - XW'(1);

    // position of the next pixel
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          col_wrap;
    logic          row_wrap;
    logic          interior;

    assign col_x    = XW'(col_reg);
    assign row_x    = XW'(row_reg);
    assign col_wrap = (col_x >= last_col);
    assign row_wrap = (row_x >= last_row);

    // the pixel at the current position completes an interior window
    assign interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input capture
    logic [PW-1:0] pixel_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pixel_reg <= pixel;
        end
    end

    // line stores: a holds the previous row, b the row before it
    logic [PW-1:0] up1;
    logic [PW-1:0] up2;

    sobel_ram #(.DATA_W(PW), .DEPTH(sobel_pkg::MAX_WIDTH)) u_store_a (
        .clk   (clk),
        .we    (cmd.advance),
        .waddr (col_reg),
        .wdata (pixel_reg),
        .re    (cmd.capture),
        .raddr (col_reg),
        .rdata (up1)
    );

    sobel_ram #(.DATA_W(PW), .DEPTH(sobel_pkg::MAX_WIDTH)) u_store_b (
        .clk   (clk),
        .we    (cmd.advance),
        .waddr (col_reg),
        .wdata (up1),
        .re    (cmd.capture),
        .raddr (col_reg),
        .rdata (up2)
    );

    // 3x3 window, rows top to bottom, oldest column first
    logic [PW-1:0] win_reg [0:8];
    logic          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            last_reg <= 1'b0;
        end
        else if (cmd.advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= up2;
            win_reg[5] <= up1;
            win_reg[8] <= pixel_reg;
            last_reg   <= row_wrap && col_wrap;
        end
    end

    // sobel gradients
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic        [SW-1:0] sx_neg;
    logic        [SW-1:0] sy_neg;
    logic        [AW-1:0] ax_reg;
    logic        [AW-1:0] ay_reg;

    assign sx = sobel_pkg::to_sum(win_reg[0]) - sobel_pkg::to_sum(win_reg[2])
              + (sobel_pkg::to_sum(win_reg[3]) <<< 1) - (sobel_pkg::to_sum(win_reg[5]) <<< 1)
              + sobel_pkg::to_sum(win_reg[6]) - sobel_pkg::to_sum(win_reg[8]);
    assign sy = sobel_pkg::to_sum(win_reg[6]) + (sobel_pkg::to_sum(win_reg[7]) <<< 1)
              + sobel_pkg::to_sum(win_reg[8]) - sobel_pkg::to_sum(win_reg[0])
              - (sobel_pkg::to_sum(win_reg[1]) <<< 1) - sobel_pkg::to_sum(win_reg[2]);
    assign sx_neg = SW'(-sx);
    assign sy_neg = SW'(-sy);

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            ax_reg <= sx[SW-1] ? sx_neg[AW-1:0] : sx[AW-1:0];
            ay_reg <= sy[SW-1] ? sy_neg[AW-1:0] : sy[AW-1:0];
        end
    end

    // squares and the digit-by-digit square root
    logic [QW-1:0] ax_sq;
    logic [QW-1:0] ay_sq;
    logic [QW-1:0] sq_reg;
    logic [QW-1:0] rem_reg;
    logic [QW-1:0] root_reg;
    logic [QW-1:0] bit_reg;
    logic [QW-1:0] trial;

    assign ax_sq = QW'(ax_reg) * QW'(ax_reg);
    assign ay_sq = QW'(ay_reg) * QW'(ay_reg);
    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square_x)
        begin
            sq_reg <= ax_sq;
        end
        if (cmd.square_y)
        begin
            rem_reg  <= sq_reg + ay_sq;
            root_reg <= '0;
            bit_reg  <= QW'(1) << (QW - 2);
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // output register
    logic          out_valid_reg;
    logic [MW-1:0] mag_reg;
    logic          edge_reg;
    logic          flast_reg;
    logic [MW-1:0] mag_val;

    assign mag_val = root_reg[MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mag_reg   <= mag_val;
            edge_reg  <= (MW'(mag_val) >= MW'(thresh_reg));
            flast_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign magnitude  = mag_reg;
    assign edge_res   = edge_reg;
    assign frame_last = flast_reg;

    assign status.has_result = interior;
    assign status.root_last  = bit_reg[0];
    assign status.out_free   = !out_valid_reg || out_ready;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mag_reg <= MW'(sobel_pkg::MAG_MAX)))
        else $error("magnitude out of range");

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_step |-> $onehot(bit_reg))
        else $error("square root step without a live bit");
`endif

endmodule

>>> sv/sobel_edge_threshold.sv
// an interior pixel's result is loaded into the output register after the square root; a border
//   pixel gives no result and the next transaction is accepted after its window step
// one transaction at a time inside the frame: capture, window, gradient,
//   two squares, 11 square root steps and the output load, which waits while a result is held
// reset: rst_n is asynchronous and clears positions, window, control and output valid, and sets the
//   configuration registers to their defaults; line stores are not cleared and need no clearing pass
module sobel_edge_threshold (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port, no read-back
    input  logic                                 cfg_write,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel stream in, raster order
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]          pixel,
    // result stream out, interior pixels only
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sobel_pkg::MAG_W-1:0]          magnitude,
    output logic                                 edge_res,
    output logic                                 frame_last
);

    // command and status between sequencer and datapath
    sobel_pkg::sobel_cmd_t    cmd;
    sobel_pkg::sobel_status_t status;

    // sequencer: accept, window step, gradient, squares, root, output hand-off
    sobel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: config registers, two line stores, window and arithmetic;
    // the output register lets the next transaction start while a result waits
    sobel_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .magnitude  (magnitude),
        .edge_res   (edge_res),
        .frame_last (frame_last)
    );

endmodule
